>>> design/masked_byte_pattern_scanner_assert.svh
// Assertion macros shared by the scanner's assertion checks.
`ifndef MASKED_BYTE_PATTERN_SCANNER_ASSERT_SVH
`define MASKED_BYTE_PATTERN_SCANNER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define MBPS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mbps assertion failed");

// Next-cycle implication, disabled while reset is held.
`define MBPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mbps assertion failed");

`endif

>>> design/mbps_pkg.sv
// Types and constants shared by the masked byte pattern scanner.
package mbps_pkg;

    localparam int PAT_BYTES = 16;
    localparam int ADDR_W    = 64;
    localparam int WORD_W    = 64;
    localparam int CARE_W    = 16;
    localparam int PLEN_W    = 5;
    localparam int REG_IDX_W = 3;

    localparam logic [PLEN_W-1:0] PLEN_RESET = 5'd1;

    // Configuration register indexes.
    typedef enum logic [REG_IDX_W-1:0] {
        REG_PAT_LO = 3'd0,
        REG_PAT_HI = 3'd1,
        REG_CARE   = 3'd2,
        REG_PLEN   = 3'd3,
        REG_BASE   = 3'd4
    } t_reg_idx;

    // Current configuration as seen by the datapath.
    typedef struct packed {
        logic [WORD_W-1:0] pat_lo;
        logic [WORD_W-1:0] pat_hi;
        logic [CARE_W-1:0] care;
        logic [PLEN_W-1:0] plen;
        logic [ADDR_W-1:0] base;
    } t_cfg;

endpackage

>>> design/mbps_ifs.sv
// Channel interfaces of the masked byte pattern scanner.

// Byte stream input channel.
interface mbps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// Search result channel.
interface mbps_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [63:0] match_address;

    modport source (output valid, output found, output match_address, input ready);
    modport sink   (input valid, input found, input match_address, output ready);
endinterface

// Configuration write channel.
interface mbps_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  reg_index;
    logic [63:0] wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

>>> design/mbps_cfg_regs.sv
// Configuration register file of the masked byte pattern scanner.
module mbps_cfg_regs
    import mbps_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    mbps_cfg_if.sink     i_cfg,
    output t_cfg         o_cfg
);

    t_cfg r_cfg;

    // Writes are always taken.
    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register write decode; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pat_lo <= '0;
            r_cfg.pat_hi <= '0;
            r_cfg.care   <= '0;
            r_cfg.plen   <= PLEN_RESET;
            r_cfg.base   <= '0;
        end else if (i_cfg.valid) begin
            case (t_reg_idx'(i_cfg.reg_index))
                REG_PAT_LO: r_cfg.pat_lo <= i_cfg.wr_data;
                REG_PAT_HI: r_cfg.pat_hi <= i_cfg.wr_data;
                REG_CARE:   r_cfg.care   <= i_cfg.wr_data[CARE_W-1:0];
                REG_PLEN:   r_cfg.plen   <= i_cfg.wr_data[PLEN_W-1:0];
                REG_BASE:   r_cfg.base   <= i_cfg.wr_data;
                default: begin
                end
            endcase
        end
    end

endmodule

>>> design/mbps_scan.sv
// Input register, sliding window, byte counter and parallel masked compare.
module mbps_scan
    import mbps_pkg::*;
#(
    parameter int MAX_PATTERN = 16,
    parameter int OFFSET_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  logic                   i_vld,
    input  logic [7:0]             i_byte,
    input  logic                   i_last,
    output logic                   o_rdy,
    output logic                   o_vld,
    output logic                   o_found,
    output logic [OFFSET_BITS-1:0] o_offset,
    input  logic                   i_rdy
);

    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    // Input register.
    logic       r_s0_vld;
    logic [7:0] r_s0_byte;
    logic       r_s0_last;

    // Region state.
    logic [7:0]             r_win [MAX_PATTERN];
    logic [7:0]             n_win [MAX_PATTERN];
    logic [OFFSET_BITS-1:0] r_cnt;
    logic [OFFSET_BITS-1:0] n_cnt;
    logic                   r_done;

    // Result register.
    logic                   r_s1_vld;
    logic                   r_s1_found;
    logic [OFFSET_BITS-1:0] r_s1_off;

    logic                   adv0;
    logic                   s1_free;
    logic [LW-1:0]          len;
    logic                   len_zero;
    logic                   was_empty;
    logic [MAX_PATTERN-1:0] pos_ok;
    logic                   all_ok;
    logic                   hit;
    logic                   emit;
    logic [OFFSET_BITS-1:0] offset;
    logic [8*PAT_BYTES-1:0] pat_all;

    // Pipeline flow control.
    assign s1_free = !r_s1_vld || i_rdy;
    assign adv0    = r_s0_vld && s1_free;
    assign o_rdy   = !r_s0_vld || adv0;

    // Effective pattern length, capped at the window depth.
    assign len      = (32'(i_cfg.plen) > MAX_PATTERN) ? LW'(MAX_PATTERN) : LW'(i_cfg.plen);
    assign len_zero = (len == '0);
    assign pat_all  = {i_cfg.pat_hi, i_cfg.pat_lo};

    // Window after shifting in the current byte, newest at index 0.
    always_comb begin
        n_win[0] = r_s0_byte;
        for (int j = 1; j < MAX_PATTERN; j++) begin
            n_win[j] = r_win[j-1];
        end
    end

    // Saturating byte count.
    assign n_cnt     = (r_cnt == '1) ? r_cnt : r_cnt + 1'b1;
    assign was_empty = (r_cnt == '0);

    // Per pattern position: pattern byte k sits len-1-k places back in the window.
    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_pos
        logic [IW-1:0] idx;
        assign idx = IW'(len - LW'(k + 1));
        if (k < PAT_BYTES) begin : g_cared
            assign pos_ok[k] = (LW'(k) >= len) || !i_cfg.care[k]
                               || (n_win[idx] == pat_all[8*k +: 8]);
        end else begin : g_wild
            assign pos_ok[k] = 1'b1;
        end
    end

    assign all_ok = &pos_ok;

    // Match decision; an empty pattern matches on the first byte at offset zero.
    assign hit    = !r_done && (len_zero ? was_empty
                                         : ((n_cnt >= OFFSET_BITS'(len)) && all_ok));
    assign emit   = hit || (!r_done && r_s0_last);
    assign offset = len_zero ? '0 : n_cnt - OFFSET_BITS'(len);

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (o_rdy) begin
            r_s0_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_s0_byte <= i_byte;
            r_s0_last <= i_last;
        end
    end

    // Region state: a final byte clears it, a finished region holds it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < MAX_PATTERN; j++) begin
                r_win[j] <= '0;
            end
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (adv0) begin
            if (r_s0_last) begin
                for (int j = 0; j < MAX_PATTERN; j++) begin
                    r_win[j] <= '0;
                end
                r_cnt  <= '0;
                r_done <= 1'b0;
            end else if (!r_done) begin
                r_win  <= n_win;
                r_cnt  <= n_cnt;
                r_done <= hit;
            end
        end
    end

    // Result register; items without a result leave it empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (adv0) begin
            r_s1_vld <= emit;
        end else if (i_rdy) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv0) begin
            r_s1_found <= hit;
            r_s1_off   <= offset;
        end
    end

    assign o_vld    = r_s1_vld;
    assign o_found  = r_s1_found;
    assign o_offset = r_s1_off;

endmodule

>>> design/mbps_out_stage.sv
// Address formation and output register of the masked byte pattern scanner.
module mbps_out_stage
    import mbps_pkg::*;
#(
    parameter int OFFSET_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [ADDR_W-1:0]      i_base,
    input  logic                   i_vld,
    input  logic                   i_found,
    input  logic [OFFSET_BITS-1:0] i_offset,
    output logic                   o_rdy,
    mbps_out_if.source             o_out
);

    logic              r_vld;
    logic              r_found;
    logic [ADDR_W-1:0] r_addr;

    assign o_rdy = !r_vld || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    // A miss reports address zero.
    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_found <= i_found;
            r_addr  <= i_found ? i_base + ADDR_W'(i_offset) : '0;
        end
    end

    assign o_out.valid         = r_vld;
    assign o_out.found         = r_found;
    assign o_out.match_address = r_addr;

endmodule

>>> design/masked_byte_pattern_scanner.sv
// Throughput: one byte per cycle while the output is not stalled.
// A three-register pipeline (input, compare, address add) carries each result to the output.
// Bytes that cause no result leave no bubble at the output.
// Reset (synchronous, active low) clears the window, byte count and match flag,
// sets the pattern length to one and all other configuration registers to zero.
module masked_byte_pattern_scanner
    import mbps_pkg::*;
#(
    parameter int MAX_PATTERN = 16,
    parameter int OFFSET_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mbps_in_if.sink     i_in,
    mbps_out_if.source  o_out,
    mbps_cfg_if.sink    i_cfg
);

`include "masked_byte_pattern_scanner_assert.svh"

    t_cfg                   cfg_q;
    logic                   res_vld;
    logic                   res_found;
    logic [OFFSET_BITS-1:0] res_off;
    logic                   res_rdy;

    // Configuration registers.
    mbps_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg_q)
    );

    // Window, count and compare.
    mbps_scan #(
        .MAX_PATTERN (MAX_PATTERN),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_q),
        .i_vld    (i_in.valid),
        .i_byte   (i_in.data_byte),
        .i_last   (i_in.last_byte),
        .o_rdy    (i_in.ready),
        .o_vld    (res_vld),
        .o_found  (res_found),
        .o_offset (res_off),
        .i_rdy    (res_rdy)
    );

    // Address add and output register.
    mbps_out_stage #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_base   (cfg_q.base),
        .i_vld    (res_vld),
        .i_found  (res_found),
        .i_offset (res_off),
        .o_rdy    (res_rdy),
        .o_out    (o_out)
    );

    // Input back-pressure only arises from a stalled, full output.
    `MBPS_ASSERT_IMPL(a_stall_source, i_clk, i_rst_n, !i_in.ready, o_out.valid && !o_out.ready)
    // A miss always reports address zero.
    `MBPS_ASSERT_IMPL(a_miss_addr, i_clk, i_rst_n, o_out.valid && !o_out.found, o_out.match_address == '0)
    // A result waiting in the compare stage moves on once the output frees up.
    `MBPS_ASSERT_NEXT(a_res_moves, i_clk, i_rst_n, res_vld && res_rdy, o_out.valid)

endmodule

>>> test/tb_masked_byte_pattern_scanner.sv
`timescale 1ns / 100ps
// Self-checking testbench for the masked byte pattern scanner: directed and random regions.
module tb_masked_byte_pattern_scanner
    import mbps_pkg::*;
();

    localparam int COUNT_W      = 32;
    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 5;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int GAP_PERCENT  = 23;
    localparam int RANDOM_BYTES = 330;
    localparam int CYCLE_LIMIT  = 300000;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] address;
    } t_search_result;

    typedef logic [7:0] t_byte_q[$];

    logic i_clk = 1'b0;
    logic i_rst_n;

    mbps_in_if  scan_if ();
    mbps_out_if hit_if ();
    mbps_cfg_if cfg_if ();

    masked_byte_pattern_scanner #(
        .MAX_PATTERN (PAT_BYTES),
        .OFFSET_BITS (COUNT_W)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (scan_if),
        .o_out   (hit_if),
        .i_cfg   (cfg_if)
    );

    // Shadow copy of the scanner's registers and search state.
    t_cfg               shadow_cfg;
    logic [7:0]         shadow_window [PAT_BYTES];
    logic [COUNT_W-1:0] shadow_seen;
    logic               shadow_done;

    // Search results still owed by the scanner, oldest first.
    t_search_result search_results_due[$];

    int unsigned bytes_scanned = 0;
    int unsigned error_count   = 0;
    int unsigned cycle_count   = 0;
    int unsigned hold_left;
    logic        src_gaps;
    logic        sink_gaps;
    logic        hold_go;

    // Free-running clock.
    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Start a fresh region in the shadow state.
    function automatic void clear_region();
        for (int j = 0; j < PAT_BYTES; j++) shadow_window[j] = '0;
        shadow_seen = '0;
        shadow_done = 1'b0;
    endfunction

    function automatic logic [7:0] pattern_byte(input int k);
        logic [2*WORD_W-1:0] both;
        both = {shadow_cfg.pat_hi, shadow_cfg.pat_lo};
        return both[8*k +: 8];
    endfunction

    function automatic int active_length();
        return (shadow_cfg.plen > PAT_BYTES) ? PAT_BYTES : int'(shadow_cfg.plen);
    endfunction

    // True when every cared-for position matches; pattern byte 0 is the oldest byte.
    function automatic logic window_hit(input int len);
        for (int k = 0; k < len; k++) begin
            if (shadow_cfg.care[k] && shadow_window[len-1-k] != pattern_byte(k)) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Advance the shadow search by one byte and record the result it owes, if any.
    function automatic void advance_search(input logic [7:0] b, input logic last);
        logic           was_empty;
        logic           hit;
        int             len;
        t_search_result res;
        hit = 1'b0;
        res = '0;
        len = active_length();
        if (!shadow_done) begin
            was_empty = (shadow_seen == '0);
            for (int j = PAT_BYTES - 1; j > 0; j--) shadow_window[j] = shadow_window[j-1];
            shadow_window[0] = b;
            if (shadow_seen != '1) shadow_seen++;
            if (len == 0) begin
                hit = was_empty;
                res.address = shadow_cfg.base;
            end else if (shadow_seen >= len && window_hit(len)) begin
                hit = 1'b1;
                res.address = shadow_cfg.base + ADDR_W'(shadow_seen - COUNT_W'(len));
            end
            if (hit) begin
                res.found = 1'b1;
                search_results_due.push_back(res);
                shadow_done = 1'b1;
            end else if (last) begin
                search_results_due.push_back('0);
            end
        end
        if (last) clear_region();
    endfunction

    function automatic void apply_register(input t_reg_idx idx, input logic [63:0] data);
        case (idx)
            REG_PAT_LO: shadow_cfg.pat_lo = data;
            REG_PAT_HI: shadow_cfg.pat_hi = data;
            REG_CARE:   shadow_cfg.care   = data[CARE_W-1:0];
            REG_PLEN:   shadow_cfg.plen   = data[PLEN_W-1:0];
            REG_BASE:   shadow_cfg.base   = data;
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch in %s at cycle %0d: got %h, want %h", what, cycle_count, got, want);
        error_count++;
    endtask

    // Result receiver: random stalls plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hit_if.ready <= 1'b0;
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hit_if.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_go) begin
            hit_if.ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
        end else begin
            hit_if.ready <= !sink_gaps || ($urandom_range(99) >= GAP_PERCENT);
        end
    end

    // Compare each result transaction with the oldest owed result.
    always @(posedge i_clk) begin : result_check
        t_search_result want;
        if (i_rst_n && hit_if.valid && hit_if.ready) begin
            if (search_results_due.size() == 0) begin
                report_mismatch("unexpected result", {63'b0, hit_if.found}, hit_if.match_address);
            end else begin
                want = search_results_due.pop_front();
                if (hit_if.found !== want.found)
                    report_mismatch("found flag", {63'b0, hit_if.found}, {63'b0, want.found});
                if (hit_if.match_address !== want.address)
                    report_mismatch("match address", hit_if.match_address, want.address);
            end
        end
    end

    // Offer one byte and wait for its transaction.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while (src_gaps && $urandom_range(99) < GAP_PERCENT) begin
            scan_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        scan_if.valid <= 1'b1;
        scan_if.data_byte <= b;
        scan_if.last_byte <= last;
        @(posedge i_clk);
        while (!scan_if.ready) @(posedge i_clk);
        bytes_scanned++;
        advance_search(b, last);
    endtask

    task automatic send_region(input t_byte_q bytes);
        foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
    endtask

    // Wait until every owed result is back and the pipeline has emptied.
    task automatic settle();
        scan_if.valid <= 1'b0;
        while (search_results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [63:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.reg_index <= idx;
        cfg_if.wr_data <= data;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        apply_register(idx, data);
    endtask

    task automatic program_scanner(input logic [63:0] pat_lo, input logic [63:0] pat_hi,
                                   input logic [63:0] care, input logic [63:0] plen,
                                   input logic [63:0] base);
        settle();
        write_reg(REG_PAT_LO, pat_lo);
        write_reg(REG_PAT_HI, pat_hi);
        write_reg(REG_CARE, care);
        write_reg(REG_PLEN, plen);
        write_reg(REG_BASE, base);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic t_byte_q random_bytes(input int n);
        t_byte_q q;
        for (int i = 0; i < n; i++) q.push_back(8'($urandom_range(255)));
        return q;
    endfunction

    // Bytes that match the current pattern, with random content at wildcards.
    function automatic t_byte_q planted_bytes();
        t_byte_q q;
        for (int k = 0; k < active_length(); k++)
            q.push_back(shadow_cfg.care[k] ? pattern_byte(k) : 8'($urandom_range(255)));
        return q;
    endfunction

    // Mostly regions holding the pattern; the rest broken, cut short or pure noise.
    function automatic t_byte_q random_region();
        t_byte_q region;
        t_byte_q body;
        int      kind;
        int      len;
        int      k;
        int      cut;
        kind = $urandom_range(9);
        len = active_length();
        region = random_bytes($urandom_range(6));
        body = planted_bytes();
        if (kind == 6 || kind == 7) begin
            // Broken match: a randomly picked byte, if cared for, differs in one bit.
            if (len > 0) begin
                k = $urandom_range(len - 1);
                if (shadow_cfg.care[k]) body[k] = body[k] ^ (8'h01 << $urandom_range(7));
            end
        end
        if (kind == 8) begin
            region = random_bytes($urandom_range(1, 20));
        end else if (kind == 9) begin
            cut = (len == 0) ? 0 : $urandom_range(len - 1);
            for (int i = 0; i < cut; i++) region.push_back(body[i]);
        end else begin
            region = {region, body, random_bytes($urandom_range(4))};
        end
        if (region.size() == 0) region.push_back(8'($urandom_range(255)));
        return region;
    endfunction

    task automatic random_setup();
        logic [63:0] plen_w;
        logic [63:0] care_w;
        logic [63:0] base_w;
        case ($urandom_range(9))
            0: plen_w = 64'd0;
            1: plen_w = 64'd16;
            2: plen_w = 64'($urandom_range(17, 31));
            3: plen_w = 64'd1;
            default: plen_w = 64'($urandom_range(2, 15));
        endcase
        // Upper bits beyond the register width must be dropped.
        if ($urandom_range(3) == 0) plen_w = plen_w | ({$urandom, $urandom} << PLEN_W);
        case ($urandom_range(3))
            0: care_w = '1;
            1: care_w = '0;
            default: care_w = {$urandom, $urandom};
        endcase
        base_w = ($urandom_range(4) == 0) ? '1 : {$urandom, $urandom};
        program_scanner({$urandom, $urandom}, {$urandom, $urandom}, care_w, plen_w, base_w);
    endtask

    // Reset leaves a one-byte pattern with no cared bytes at base zero.
    task automatic test_reset_state();
        send_region('{8'hFF, 8'h00});
    endtask

    // Care mask and length registers ignore bits above their width.
    task automatic test_register_masking();
        program_scanner(64'h0000_0000_0000_1234, 64'h0, 64'hFFFF_FFFF_FFFF_0003,
                        64'hFFFF_FFFF_FFFF_FFE2, 64'h1000);
        send_region('{8'h12, 8'h34, 8'h12});
    endtask

    // A zero-length pattern hits at the first byte of every region.
    task automatic test_empty_pattern();
        program_scanner(64'h0, 64'h0, 64'hFFFF, 64'd0, '1);
        send_region('{8'hA5});
        send_region('{8'h00, 8'hFF});
    endtask

    // Overlong length acts as sixteen; the match completes on the region's final byte.
    task automatic test_overlong_full_match();
        t_byte_q region;
        program_scanner(64'h00FF_00FF_00FF_00FF, 64'hFF00_FF00_FF00_FF00, 64'hFFFF, 64'd31,
                        64'h8000_0000_0000_0000);
        for (int k = 0; k < PAT_BYTES; k++) region.push_back(pattern_byte(k));
        send_region(region);
    endtask

    // Wildcard in the middle, address wrap past the top, and a region too short to match.
    task automatic test_wildcards_and_wrap();
        program_scanner(64'h0000_0000_00CC_BBAA, 64'h0, 64'h5, 64'd3, '1);
        send_region('{8'h01, 8'hAA, 8'h99, 8'hCC, 8'h44});
        send_region('{8'hAA, 8'h00});
    endtask

    // Random settings and regions; the first phase runs with no idling on either side.
    task automatic test_random_regions();
        int unsigned start;
        int          phase;
        start = bytes_scanned;
        phase = 0;
        while (bytes_scanned - start < RANDOM_BYTES) begin
            random_setup();
            src_gaps <= (phase != 0);
            sink_gaps <= (phase != 0);
            repeat ($urandom_range(3, 8)) send_region(random_region());
            phase++;
        end
    endtask

    // The receiver holds off while bytes keep coming, so the scanner fills and stalls.
    task automatic test_output_stall();
        random_setup();
        src_gaps <= 1'b0;
        hold_go <= 1'b1;
        @(posedge i_clk);
        hold_go <= 1'b0;
        repeat (40) send_region(random_bytes($urandom_range(1, 3)));
        settle();
        src_gaps <= 1'b1;
    endtask

    initial begin
        i_rst_n <= 1'b0;
        scan_if.valid <= 1'b0;
        scan_if.data_byte <= '0;
        scan_if.last_byte <= 1'b0;
        cfg_if.valid <= 1'b0;
        cfg_if.reg_index <= REG_PAT_LO;
        cfg_if.wr_data <= '0;
        src_gaps <= 1'b0;
        sink_gaps <= 1'b0;
        hold_go <= 1'b0;
        shadow_cfg = '0;
        shadow_cfg.plen = PLEN_RESET;
        clear_region();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        src_gaps <= 1'b1;
        sink_gaps <= 1'b1;

        test_reset_state();
        test_register_masking();
        test_empty_pattern();
        test_overlong_full_match();
        test_wildcards_and_wrap();
        test_random_regions();
        test_output_stall();
        settle();

        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
